>>> hdl/scalar_kalman_filter_q16_defines.svh
// assertion macros shared by the scalar kalman filter rtl
`ifndef SCALAR_KALMAN_FILTER_Q16_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_Q16_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SKF_ASSERT_HOLDS(label, clk, rst, cond, result, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (result)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SKF_ASSERT_NEXT(label, clk, rst, cond, result, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (result)) \
    else $error(msg);

`endif

>>> hdl/skf_pkg.sv
// shared types and constants of the scalar kalman filter
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

  localparam int VAR_WIDTH   = 34;
  localparam int DEN_WIDTH   = 35;
  localparam int REG_WIDTH   = 32;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_VARIANCE     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_VARIANCE = 1'b1;

  localparam logic [REG_WIDTH-1:0] VARIANCE_RESET = 32'd65536;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } skf_state_t;

  // one quotient bit per cycle, msb first
  typedef struct packed {
    logic valid;
    logic qbit;
    logic last;
  } skf_div_bit_t;

endpackage

`default_nettype wire

>>> hdl/skf_div.sv
// bit-serial restoring divider for the gain, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module skf_div #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [skf_pkg::VAR_WIDTH-1:0]     p,
  input  logic [skf_pkg::DEN_WIDTH-1:0]     d,
  output skf_pkg::skf_div_bit_t             q
);

  localparam int DW    = skf_pkg::DEN_WIDTH;
  localparam int VW    = skf_pkg::VAR_WIDTH;
  localparam int CNT_W = $clog2(FRACTION_BITS + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    den;
  logic             lsb;
  logic             den_zero;
  logic             busy;
  logic [CNT_W-1:0] cnt;

  logic          in_bit;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;
  logic          last;

  assign in_bit  = (cnt == '0) ? lsb : 1'b0;
  assign shifted = {rem, in_bit};
  assign diff    = shifted - {1'b0, den};
  assign ge      = shifted >= {1'b0, den};
  assign last    = busy && (cnt == CNT_W'(FRACTION_BITS));

  assign q.valid = busy;
  assign q.qbit  = busy && ge && !den_zero;
  assign q.last  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {2'b00, p[VW-1:1]};
      lsb      <= p[0];
      den      <= d;
      den_zero <= (d == '0);
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
    end
  end

endmodule

`default_nettype wire

>>> hdl/scalar_kalman_filter_q16.sv
// scalar kalman filter top level: one filtered estimate for each measurement word
//
// channels: s_axis carries one signed measurement word, m_axis one estimate word;
// a word moves when tvalid and tready are both high. cfg_we with cfg_index and
// cfg_data writes process variance (index 0) or measurement variance (index 1).
// the first measurement after reset is passed through: once it is accepted, the
// filter goes straight to its finishing state, which loads the output register.
// every later measurement is accepted, runs through the bit-serial gain divider,
// and then through the finishing state, which loads the output register and so
// raises tvalid. both gain products are accumulated msb first as quotient bits
// appear, so no multiply step follows the divider loop. a new measurement is
// taken only once the finishing state has passed its result to the output
// register.
// the estimate sits in an output register: a new measurement is accepted while
// it waits; if m_axis_tready stays low the next result holds in its finishing
// cycle until the register frees up.
// reset (rst, synchronous) clears the estimate, sets the error variance and both
// variance registers to 1.0 and forgets that a measurement was seen.
`timescale 1ns / 1ps
`default_nettype none
`include "scalar_kalman_filter_q16_defines.svh"

module scalar_kalman_filter_q16 #(
  parameter int SAMPLE_WIDTH  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // measurement
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // estimate
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  input  logic                                  cfg_we,
  input  logic [skf_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [skf_pkg::REG_WIDTH-1:0]         cfg_data
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int VW     = skf_pkg::VAR_WIDTH;
  localparam int DW     = skf_pkg::DEN_WIDTH;
  localparam int RW     = skf_pkg::REG_WIDTH;
  localparam int EP_W   = SAMPLE_WIDTH + FRACTION_BITS;
  localparam int VP_W   = skf_pkg::VAR_WIDTH + FRACTION_BITS;

  skf_pkg::skf_state_t   state;
  skf_pkg::skf_state_t   state_next;
  skf_pkg::skf_div_bit_t div_bit;

  logic [RW-1:0]   proc_var;
  logic [RW-1:0]   meas_var;
  logic [SW-1:0]   est;
  logic [VW-1:0]   err_var;
  logic            primed;
  logic            seed;
  logic [VW-1:0]   p_reg;
  logic [SW-1:0]   mag;
  logic            neg;
  logic [EP_W-1:0] acc_e;
  logic [VP_W-1:0] acc_p;
  logic            out_valid;
  logic [SW-1:0]   out_data;

  logic            accept;
  logic            div_start;
  logic            fin_go;
  logic            out_free;
  logic [SW-1:0]   meas;
  logic [VW-1:0]   p_sum;
  logic [DW-1:0]   den_sum;
  logic [SW:0]     diff;
  logic [SW:0]     diff_neg;
  logic [SW-1:0]   step;
  logic [SW-1:0]   est_new;
  logic [VP_W-1:0] var_rest;
  logic [VW-1:0]   err_var_new;

  assign meas     = s_axis_tdata[SW-1:0];
  assign out_free = !out_valid || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign p_sum    = err_var + {{(VW-RW){1'b0}}, proc_var};
  assign den_sum  = {1'b0, p_sum} + {{(DW-RW){1'b0}}, meas_var};
  assign diff     = {meas[SW-1], meas} - {est[SW-1], est};
  assign diff_neg = -diff;

  assign step        = acc_e[EP_W-1:FRACTION_BITS];
  assign est_new     = neg ? (est - step) : (est + step);
  assign var_rest    = (VP_W'(p_reg) << FRACTION_BITS) - acc_p;
  assign err_var_new = var_rest[VP_W-1:FRACTION_BITS];

  skf_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .p    (p_sum),
    .d    (den_sum),
    .q    (div_bit)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      skf_pkg::S_IDLE: begin
        if (accept) begin
          state_next = primed ? skf_pkg::S_DIV : skf_pkg::S_FIN;
        end
      end
      skf_pkg::S_DIV: begin
        if (div_bit.last) begin
          state_next = skf_pkg::S_FIN;
        end
      end
      skf_pkg::S_FIN: begin
        if (out_free) begin
          state_next = skf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = skf_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    fin_go        = 1'b0;
    unique case (state)
      skf_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        div_start     = s_axis_tvalid && primed;
      end
      skf_pkg::S_DIV: begin
      end
      skf_pkg::S_FIN: begin
        fin_go = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_var <= skf_pkg::VARIANCE_RESET;
      meas_var <= skf_pkg::VARIANCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        skf_pkg::REG_PROCESS_VARIANCE:     proc_var <= cfg_data;
        skf_pkg::REG_MEASUREMENT_VARIANCE: meas_var <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      est     <= '0;
      err_var <= VW'(1) << FRACTION_BITS;
      primed  <= 1'b0;
      seed    <= 1'b0;
    end else begin
      if (accept) begin
        seed <= !primed;
        if (!primed) begin
          est    <= meas;
          primed <= 1'b1;
        end
      end
      if (fin_go && !seed) begin
        est     <= est_new;
        err_var <= err_var_new;
      end
    end
  end

  // step operands and msb-first gain products
  always_ff @(posedge clk) begin
    if (div_start) begin
      p_reg <= p_sum;
      neg   <= diff[SW];
      mag   <= diff[SW] ? diff_neg[SW-1:0] : diff[SW-1:0];
      acc_e <= '0;
      acc_p <= '0;
    end else if (div_bit.valid) begin
      acc_e <= {acc_e[EP_W-2:0], 1'b0} + (div_bit.qbit ? EP_W'(mag) : '0);
      acc_p <= {acc_p[VP_W-2:0], 1'b0} + (div_bit.qbit ? VP_W'(p_reg) : '0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data <= seed ? est : est_new;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DATA_W'(out_data);

  `SKF_ASSERT_NEXT(a_div_done_to_fin, clk, rst,
    (state == skf_pkg::S_DIV) && div_bit.last, state == skf_pkg::S_FIN,
    "divider finished but filter did not enter finish")
  `SKF_ASSERT_HOLDS(a_div_busy_in_div, clk, rst,
    state == skf_pkg::S_DIV, div_bit.valid,
    "divider idle while filter waits for gain bits")
  `SKF_ASSERT_HOLDS(a_var_product_bound, clk, rst,
    (state == skf_pkg::S_FIN) && !seed, acc_p <= (VP_W'(p_reg) << FRACTION_BITS),
    "variance product exceeds unit gain")
  `SKF_ASSERT_NEXT(a_fin_loads_output, clk, rst,
    fin_go, m_axis_tvalid,
    "finished estimate not presented")

endmodule

`default_nettype wire
